/* rtl/gait_phase_timeline_top_assert.svh */
`ifndef GAIT_PHASE_TIMELINE_TOP_ASSERT_SVH
`define GAIT_PHASE_TIMELINE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define GPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define GPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/gpt_pkg.sv */
package gpt_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int LEGS_DEF  = 4;

  typedef enum logic [1:0] {
    FN_START  = 2'd0,
    FN_APPEND = 2'd1,
    FN_TRIM   = 2'd2,
    FN_QUERY  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_ISSUE,
    S_FIRST,
    S_SCAN,
    S_MUL,
    S_ADD,
    S_DONE
  } gpt_state_t;

  typedef struct packed {
    logic [31:0]      tstamp;
    logic [31:0]      phase;
    logic [23:0]      freq;
    logic [15:0]      swing;
    logic [2:0][15:0] offs;
  } seg_entry_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] time_req;
    logic [15:0] start_phase;
    logic [23:0] frequency;
    logic [15:0] swing_ratio;
    logic [15:0] offset_leg1;
    logic [15:0] offset_leg2;
    logic [15:0] offset_leg3;
  } req_word_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] phase_leg0;
    logic [15:0] phase_leg1;
    logic [15:0] phase_leg2;
    logic [15:0] phase_leg3;
    logic [3:0]  contact_flags;
    logic [23:0] seg_frequency;
    logic [15:0] seg_swing_ratio;
  } rsp_word_t;

endpackage

/* rtl/gpt_ifs.sv */
interface gpt_req_if;
  import gpt_pkg::*;

  logic      valid;
  logic      ready;
  req_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gpt_rsp_if;
  import gpt_pkg::*;

  logic      valid;
  logic      ready;
  rsp_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/gpt_seg_mem.sv */
module gpt_seg_mem #(
  parameter int DEPTH = gpt_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  gpt_pkg::seg_entry_t      wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output gpt_pkg::seg_entry_t      rd_data
);
  import gpt_pkg::*;

  seg_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/gait_phase_timeline_top.sv */
// channel | dir | payload                                      | accepted when
// req     | in  | func, time_req, start_phase, segment fields  | req.valid && req.ready
// rsp     | out | status, leg phases, contact, freq, swing     | rsp.valid && rsp.ready
//
// Start runs S_START, S_DONE; on an empty table words run S_ISSUE, S_DONE. Append, trim
// and query run S_ISSUE, S_FIRST, S_MUL, S_ADD, S_DONE; the last two add an S_SCAN per
// segment past the front. Refused appends, early queries, no-op trims skip S_MUL, S_ADD.
// One 32x24 multiplier forms every phase advance.
// rst clears state, head and count; segment storage holds no reset value.
// req.ready is high only in idle; a held rsp word stalls the next result.

`include "gait_phase_timeline_top_assert.svh"

module gait_phase_timeline_top #(
  parameter int DEPTH = gpt_pkg::DEPTH_DEF,
  parameter int LEGS  = gpt_pkg::LEGS_DEF
) (
  input logic       clk,
  input logic       rst,
  gpt_req_if.sink   req,
  gpt_rsp_if.source rsp
);
  import gpt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  gpt_state_t  state, state_next;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] k;
  logic [CW-1:0] kk;
  logic [AW-1:0] slot_k;
  logic [AW-1:0] wr_slot;
  req_word_t   cur;
  seg_entry_t  held;
  seg_entry_t  rd_data;
  seg_entry_t  wr_data;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0] dt;
  logic [31:0] prod;
  logic [55:0] prod_full;
  logic [31:0] ph;
  logic        lt, early;
  logic [15:0] leg_off [4];
  logic [15:0] leg_ph  [4];
  logic [3:0]  flags;
  rsp_word_t   res;
  rsp_word_t   out_q;
  logic        out_valid;
  logic        out_free;

  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] h, logic [CW-1:0] n);
    logic [CW:0] sum;
    sum = (CW+1)'(h) + (CW+1)'(n);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  gpt_seg_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (slot_k),
    .rd_data (rd_data)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;
  assign out_free  = !out_valid || rsp.ready;

  assign lt        = rd_data.tstamp < cur.time_req;
  assign early     = cur.time_req < rd_data.tstamp;
  assign prod_full = 56'(dt) * 56'(held.freq);
  assign ph        = held.phase + prod;

  always_comb begin
    unique case (state)
      S_ISSUE: kk = (cur.func == FN_APPEND) ? count - CW'(1) : '0;
      S_FIRST: kk = CW'(1);
      S_SCAN:  kk = k + CW'(1);
      S_MUL:   kk = (cur.func == FN_APPEND) ? count : k - CW'(1);
      default: kk = '0;
    endcase
    slot_k = slot_of(head, kk);
  end

  always_comb begin
    leg_off[0] = '0;
    for (int i = 1; i < 4; i++) begin
      leg_off[i] = held.offs[i-1];
    end
    for (int i = 0; i < 4; i++) begin
      leg_ph[i] = (i < LEGS) ? ph[15:0] + leg_off[i] : '0;
      flags[i]  = (i < LEGS) && (leg_ph[i] >= held.swing);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.data.func == FN_START) ? S_START : S_ISSUE;
        end
      end
      S_START: state_next = S_DONE;
      S_ISSUE: state_next = (count == '0) ? S_DONE : S_FIRST;
      S_FIRST: begin
        if (cur.func == FN_APPEND) begin
          state_next = (!lt || count >= CW'(DEPTH)) ? S_DONE : S_MUL;
        end else if (early) begin
          state_next = S_DONE;
        end else if (!lt) begin
          state_next = (cur.func == FN_TRIM) ? S_DONE : S_MUL;
        end else begin
          state_next = (count > CW'(1)) ? S_SCAN : S_MUL;
        end
      end
      S_SCAN: begin
        if (!(lt && (k + CW'(1) < count))) begin
          state_next = S_MUL;
        end
      end
      S_MUL:  state_next = S_ADD;
      S_ADD:  state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_slot;
    wr_data = held;
    unique case (state)
      S_START: begin
        wr_en          = 1'b1;
        wr_addr        = '0;
        wr_data.tstamp = cur.time_req;
        wr_data.phase  = 32'(cur.start_phase);
        wr_data.freq   = cur.frequency;
        wr_data.swing  = cur.swing_ratio;
        wr_data.offs   = {cur.offset_leg3, cur.offset_leg2, cur.offset_leg1};
      end
      S_ADD: begin
        wr_en          = (cur.func != FN_QUERY);
        wr_data.tstamp = cur.time_req;
        wr_data.phase  = ph;
        if (cur.func == FN_APPEND) begin
          wr_data.freq  = cur.frequency;
          wr_data.swing = cur.swing_ratio;
          wr_data.offs  = {cur.offset_leg3, cur.offset_leg2, cur.offset_leg1};
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_START) begin
        head  <= '0;
        count <= CW'(1);
      end
      if (state == S_MUL && cur.func == FN_TRIM) begin
        head  <= slot_k;
        count <= count - (k - CW'(1));
      end
      if (state == S_ADD && cur.func == FN_APPEND) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          cur <= req.data;
          res <= '0;
        end
      end
      S_ISSUE: begin
        k <= CW'(1);
        if (count == '0) begin
          res.status <= ST_EMPTY;
        end
      end
      S_FIRST: begin
        held <= rd_data;
        dt   <= cur.time_req - rd_data.tstamp;
        if (cur.func == FN_APPEND) begin
          if (!lt) begin
            res.status <= ST_ORDER;
          end else if (count >= CW'(DEPTH)) begin
            res.status <= ST_FULL;
          end
        end else if (early) begin
          res.status <= ST_ORDER;
        end
      end
      S_SCAN: begin
        if (lt) begin
          held <= rd_data;
          dt   <= cur.time_req - rd_data.tstamp;
          k    <= k + CW'(1);
        end
      end
      S_MUL: begin
        prod    <= prod_full[47:16];
        wr_slot <= slot_k;
      end
      S_ADD: begin
        if (cur.func == FN_QUERY) begin
          res.phase_leg0      <= leg_ph[0];
          res.phase_leg1      <= leg_ph[1];
          res.phase_leg2      <= leg_ph[2];
          res.phase_leg3      <= leg_ph[3];
          res.contact_flags   <= flags;
          res.seg_frequency   <= held.freq;
          res.seg_swing_ratio <= held.swing;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_q <= res;
        end
      end
      default: begin
      end
    endcase
  end

  `GPT_ASSERT_NOW(a_count_max, 1'b1, count <= CW'(DEPTH), "entry count beyond depth")
  `GPT_ASSERT_NOW(a_head_range, 1'b1, head <= AW'(DEPTH - 1), "head index beyond depth")
  `GPT_ASSERT_NOW(a_start_load, $past(state) == S_START,
    count == CW'(1) && head == '0, "start did not load a single segment")
  `GPT_ASSERT_NEXT(a_append_grow, state == S_ADD && cur.func == FN_APPEND,
    count == $past(count) + CW'(1), "append did not grow the ring")
  `GPT_ASSERT_NOW(a_fail_zero, rsp.valid && rsp.data.status != ST_OK,
    rsp.data.phase_leg0 == '0 && rsp.data.contact_flags == '0 &&
    rsp.data.seg_frequency == '0, "failed word carries payload")

endmodule

/* bench/gait_phase_timeline_top_tb.sv */
`timescale 1ns / 1ps

module gait_phase_timeline_top_tb;
  import gpt_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int RANDOM_WORDS = 1300;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT = 500000;

  class timeline_book;
    logic [31:0] seg_t   [DEPTH];
    logic [31:0] seg_ph  [DEPTH];
    logic [23:0] seg_f   [DEPTH];
    logic [15:0] seg_sw  [DEPTH];
    logic [15:0] seg_off [DEPTH][3];
    int unsigned head = 0;
    int unsigned count = 0;
    rsp_word_t   owed_rsp[$];
    int          errors = 0;

    function int unsigned slot(int unsigned k);
      return (head + k) % DEPTH;
    endfunction

    function logic [31:0] advanced(logic [31:0] ph, logic [31:0] dt, logic [23:0] f);
      logic [55:0] prod;
      prod = 56'(dt) * 56'(f);
      return ph + prod[47:16];
    endfunction

    function void load(int unsigned s, req_word_t w, logic [31:0] ph);
      seg_t[s]      = w.time_req;
      seg_ph[s]     = ph;
      seg_f[s]      = w.frequency;
      seg_sw[s]     = w.swing_ratio;
      seg_off[s][0] = w.offset_leg1;
      seg_off[s][1] = w.offset_leg2;
      seg_off[s][2] = w.offset_leg3;
    endfunction

    function void log_request(req_word_t w);
      rsp_word_t   r;
      int unsigned front, last, idx, k, s;
      logic [31:0] ph;
      logic [15:0] leg_ph [4];
      r = '0;
      if (w.func == FN_START) begin
        head = 0;
        count = 1;
        load(0, w, {16'd0, w.start_phase});
      end else if (count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        front = slot(0);
        case (w.func)
          FN_APPEND: begin
            last = slot(count - 1);
            if (w.time_req <= seg_t[last]) begin
              r.status = ST_ORDER;
            end else if (count >= DEPTH) begin
              r.status = ST_FULL;
            end else begin
              ph = advanced(seg_ph[last], w.time_req - seg_t[last], seg_f[last]);
              load(slot(count), w, ph);
              count++;
            end
          end
          FN_TRIM: begin
            if (w.time_req < seg_t[front]) begin
              r.status = ST_ORDER;
            end else begin
              idx = 0;
              while (idx < count && seg_t[slot(idx)] < w.time_req) idx++;
              if (idx != 0) begin
                s = slot(idx - 1);
                head = s;
                count -= idx - 1;
                seg_ph[s] = advanced(seg_ph[s], w.time_req - seg_t[s], seg_f[s]);
                seg_t[s] = w.time_req;
              end
            end
          end
          FN_QUERY: begin
            if (w.time_req < seg_t[front]) begin
              r.status = ST_ORDER;
            end else begin
              if (w.time_req == seg_t[front]) begin
                s = front;
                ph = seg_ph[s];
              end else begin
                k = 0;
                while (k + 1 < count && seg_t[slot(k + 1)] < w.time_req) k++;
                s = slot(k);
                ph = advanced(seg_ph[s], w.time_req - seg_t[s], seg_f[s]);
              end
              leg_ph[0] = ph[15:0];
              for (k = 1; k < 4; k++) leg_ph[k] = ph[15:0] + seg_off[s][k - 1];
              for (k = 0; k < 4; k++) r.contact_flags[k] = leg_ph[k] >= seg_sw[s];
              r.phase_leg0      = leg_ph[0];
              r.phase_leg1      = leg_ph[1];
              r.phase_leg2      = leg_ph[2];
              r.phase_leg3      = leg_ph[3];
              r.seg_frequency   = seg_f[s];
              r.seg_swing_ratio = seg_sw[s];
            end
          end
          default: ;
        endcase
      end
      owed_rsp = {owed_rsp, r};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 100) $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    endtask

    task match_response(rsp_word_t got);
      rsp_word_t want;
      if (owed_rsp.size() == 0) begin
        report("unowed word, status", 32'(got.status), 32'd0);
        return;
      end
      want = owed_rsp.pop_front();
      if (got.status !== want.status)
        report("status", 32'(got.status), 32'(want.status));
      if (got.phase_leg0 !== want.phase_leg0)
        report("phase_leg0", 32'(got.phase_leg0), 32'(want.phase_leg0));
      if (got.phase_leg1 !== want.phase_leg1)
        report("phase_leg1", 32'(got.phase_leg1), 32'(want.phase_leg1));
      if (got.phase_leg2 !== want.phase_leg2)
        report("phase_leg2", 32'(got.phase_leg2), 32'(want.phase_leg2));
      if (got.phase_leg3 !== want.phase_leg3)
        report("phase_leg3", 32'(got.phase_leg3), 32'(want.phase_leg3));
      if (got.contact_flags !== want.contact_flags)
        report("contact_flags", 32'(got.contact_flags), 32'(want.contact_flags));
      if (got.seg_frequency !== want.seg_frequency)
        report("seg_frequency", 32'(got.seg_frequency), 32'(want.seg_frequency));
      if (got.seg_swing_ratio !== want.seg_swing_ratio)
        report("seg_swing_ratio", 32'(got.seg_swing_ratio), 32'(want.seg_swing_ratio));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   idle_on = 1'b1;
  bit   hold_go = 1'b0;
  int   cycles = 0;

  timeline_book book = new;

  gpt_req_if req_bus ();
  gpt_rsp_if rsp_bus ();

  gait_phase_timeline_top uut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_bus.valid && req_bus.ready) book.log_request(req_bus.data);
      if (rsp_bus.valid && rsp_bus.ready) book.match_response(rsp_bus.data);
    end
  end

  initial begin
    int held;
    held = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        rsp_bus.ready <= 1'b0;
      end else if (hold_go && held < HOLD_CYCLES) begin
        rsp_bus.ready <= 1'b0;
        held++;
      end else begin
        rsp_bus.ready <= !(idle_on && $urandom_range(99) < 36);
      end
    end
  end

  function automatic req_word_t rand_word(func_t fn, logic [31:0] t);
    req_word_t   w;
    int unsigned r;
    r = $urandom_range(99);
    w.func        = fn;
    w.time_req    = t;
    w.start_phase = 16'($urandom());
    w.frequency   = r < 25 ? 24'($urandom_range(0, 32'h0002_0000)) : 24'($urandom());
    w.swing_ratio = r % 10 == 0 ? 16'h0000 : r % 10 == 1 ? 16'hFFFF : 16'($urandom());
    w.offset_leg1 = 16'($urandom());
    w.offset_leg2 = 16'($urandom());
    w.offset_leg3 = 16'($urandom());
    return w;
  endfunction

  function automatic req_word_t pick_word();
    int unsigned r, k;
    logic [31:0] front_t, last_t, base, t;
    func_t       fn;
    r = $urandom_range(99);
    fn = r < 6 ? FN_START : r < 46 ? FN_APPEND : r < 60 ? FN_TRIM : FN_QUERY;
    if (book.count == 0) fn = FN_START;
    front_t = book.seg_t[book.slot(0)];
    last_t  = book.seg_t[book.slot(book.count - 1)];
    k = $urandom_range(book.count - 1);
    base = book.seg_t[book.slot(k)];
    r = $urandom_range(99);
    case (fn)
      FN_START: t = r < 70 ? $urandom_range(32'h00FF_FFFF) : $urandom();
      FN_APPEND: begin
        if (r < 85) t = last_t + $urandom_range(1, 32'h0004_0000);
        else if (r < 93) t = last_t - $urandom_range(0, 16);
        else t = $urandom();
      end
      default: begin
        if (r < 12) t = front_t;
        else if (r < 22) t = base;
        else if (r < 30) t = front_t - $urandom_range(1, 32'h0001_0000);
        else if (r < 36) t = $urandom();
        else t = base + $urandom_range(1, 32'h0003_0000);
      end
    endcase
    return rand_word(fn, t);
  endfunction

  task automatic wait_slot();
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 36) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic drive(input req_word_t w);
    req_bus.valid <= 1'b1;
    req_bus.data  <= w;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
  endtask

  task automatic send(input req_word_t w);
    wait_slot();
    drive(w);
  endtask

  initial begin
    req_word_t   w;
    logic [31:0] last_t;
    req_bus.valid = 1'b0;
    req_bus.data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    send(rand_word(FN_QUERY, 32'h0000_0000));
    send(rand_word(FN_APPEND, 32'h0002_0000));
    send(rand_word(FN_TRIM, 32'h0001_0000));
    w = rand_word(FN_START, 32'h0001_0000);
    w.start_phase = 16'hFFFF;
    w.frequency   = 24'hFF_FFFF;
    w.swing_ratio = 16'h0000;
    w.offset_leg1 = 16'hFFFF;
    w.offset_leg2 = 16'h0000;
    w.offset_leg3 = 16'h8000;
    send(w);
    send(rand_word(FN_QUERY, 32'h0001_0000));
    send(rand_word(FN_QUERY, 32'h0000_FFFF));
    for (int i = 1; i < DEPTH; i++) begin
      w = rand_word(FN_APPEND, 32'h0001_0000 + i * 32'h0000_8000);
      if (i == 1) begin
        w.frequency   = '0;
        w.swing_ratio = 16'hFFFF;
        w.offset_leg1 = '0;
        w.offset_leg2 = '0;
        w.offset_leg3 = '0;
      end
      send(w);
      if (i == 1) send(rand_word(FN_QUERY, 32'h0001_8000));
    end
    last_t = 32'h0001_0000 + (DEPTH - 1) * 32'h0000_8000;
    send(rand_word(FN_APPEND, last_t + 1));
    send(rand_word(FN_APPEND, last_t));
    send(rand_word(FN_TRIM, 32'h0000_FFFF));
    send(rand_word(FN_TRIM, 32'h0001_0000));
    send(rand_word(FN_TRIM, 32'hFFFF_FFFF));
    send(rand_word(FN_QUERY, 32'hFFFF_FFFF));

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 400) hold_go = 1'b1;
      if (i == 700) begin
        @(negedge clk) req_bus.valid <= 1'b0;
        while (book.owed_rsp.size() != 0) @(posedge clk);
      end
      idle_on = !(i >= 900 && i < 1100);
      wait_slot();
      drive(pick_word());
    end

    @(negedge clk) req_bus.valid <= 1'b0;
    while (book.owed_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
